>>> design/cka_pkg.sv
// ----------------------------------------------------------------------------
// cka_pkg
// Shared sizes, register indexes, datapath operations and the
// command and status bundles of the color key alpha halo block.
// ----------------------------------------------------------------------------
package cka_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_HALO   = 15;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int DIM_W  = 9;
	localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int HALO_W = 4;
	localparam int DIV_W  = $clog2(2 * MAX_HALO + 2);
	localparam int INC_W  = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_KEY_RED    = 3'd0;
	localparam logic [IDX_W-1:0] REG_KEY_GREEN  = 3'd1;
	localparam logic [IDX_W-1:0] REG_KEY_BLUE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_HALO_WIDTH = 3'd3;
	localparam logic [IDX_W-1:0] REG_HALO_INC   = 3'd4;
	localparam logic [IDX_W-1:0] REG_FRAME_W    = 3'd5;
	localparam logic [IDX_W-1:0] REG_FRAME_H    = 3'd6;

	typedef logic [3:0] op_t;

	// datapath operations
	localparam op_t OP_NONE      = 4'd0;
	localparam op_t OP_LOAD      = 4'd1;
	localparam op_t OP_KEY_WR    = 4'd2;
	localparam op_t OP_DIV_START = 4'd3;
	localparam op_t OP_DIV_STORE = 4'd4;
	localparam op_t OP_CTR_NEXT  = 4'd5;
	localparam op_t OP_WIN_SET   = 4'd6;
	localparam op_t OP_PT_ADDR   = 4'd7;
	localparam op_t OP_PT_WR     = 4'd8;
	localparam op_t OP_MG_WR     = 4'd9;
	localparam op_t OP_FETCH_OUT = 4'd10;

	typedef struct packed {
		op_t  op;
		logic rd_ctr;   // pixel read at sweep index, else at fetch index
		logic acc_pt;   // accumulator read at window point, else at sweep index
	} cka_cmd_t;

	typedef struct packed {
		logic load_proc;
		logic fetch_ok;
		logic last_i;
		logic keyed;
		logic win_last;
		logic div_done;
		logic d_last;
		logic s_zero;
		logic out_free;
	} cka_stat_t;

endpackage

>>> design/cka_div.sv
// ----------------------------------------------------------------------------
// cka_div
// Restoring divider, one quotient bit per cycle, for the halo increment
// divided by a small window divisor.
// ----------------------------------------------------------------------------
module cka_div import cka_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [INC_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic [INC_W-1:0] quotient,
	output logic             done
);

	localparam int STEP_W = $clog2(INC_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W:0]    rem_q;
	logic [INC_W-1:0]  quo_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [DIV_W:0]    shifted;
	logic              fits;

	// one trial subtract per cycle
	assign shifted = {rem_q[DIV_W-1:0], quo_q[INC_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(INC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
			quo_q <= {quo_q[INC_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

>>> design/cka_data.sv
// ----------------------------------------------------------------------------
// cka_data
// Datapath: configuration registers, pixel and accumulator memories,
// sweep and window counters, quotient table and output register.
// ----------------------------------------------------------------------------
module cka_data import cka_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [7:0]       in_red,
	input  logic [7:0]       in_green,
	input  logic [7:0]       in_blue,
	input  logic [7:0]       in_alpha,
	input  cka_cmd_t         cmd,
	input  logic             out_stall,
	output cka_stat_t        stat,
	output logic             out_valid,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic [7:0]       out_alpha,
	output logic             is_last
);

	localparam int QT_DEPTH = 2 ** DIV_W;

	// configuration
	logic [7:0]        key_r_q, key_g_q, key_b_q;
	logic [HALO_W-1:0] halo_w_q;
	logic [INC_W-1:0]  halo_inc_q;
	logic [DIM_W-1:0]  frame_w_q, frame_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_r_q    <= '0;
			key_g_q    <= '0;
			key_b_q    <= '0;
			halo_w_q   <= '0;
			halo_inc_q <= '0;
			frame_w_q  <= DIM_W'(256);
			frame_h_q  <= DIM_W'(256);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KEY_RED:    key_r_q    <= cfg_data[7:0];
				REG_KEY_GREEN:  key_g_q    <= cfg_data[7:0];
				REG_KEY_BLUE:   key_b_q    <= cfg_data[7:0];
				REG_HALO_WIDTH: halo_w_q   <= cfg_data[HALO_W-1:0];
				REG_HALO_INC:   halo_inc_q <= cfg_data[INC_W-1:0];
				REG_FRAME_W:    frame_w_q  <= cfg_data[DIM_W-1:0];
				REG_FRAME_H:    frame_h_q  <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped frame size and halo radius
	logic [DIM_W-1:0]  w_eff, h_eff;
	logic [HALO_W-1:0] s_eff;
	logic [CNT_W-1:0]  total;
	logic [ADDR_W-1:0] last_idx;

	always_comb begin
		if (frame_w_q == '0)
			w_eff = DIM_W'(1);
		else if (frame_w_q > DIM_W'(MAX_WIDTH))
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = frame_w_q;
		if (frame_h_q == '0)
			h_eff = DIM_W'(1);
		else if (frame_h_q > DIM_W'(MAX_HEIGHT))
			h_eff = DIM_W'(MAX_HEIGHT);
		else
			h_eff = frame_h_q;
		s_eff = (halo_w_q > HALO_W'(MAX_HALO)) ? HALO_W'(MAX_HALO) : halo_w_q;
	end

	assign total    = CNT_W'(w_eff) * CNT_W'(h_eff);
	assign last_idx = ADDR_W'(total - 1'b1);

	// frame positions
	logic [CNT_W-1:0]  lp_q;
	logic [ADDR_W-1:0] fp_q;
	logic              done_q;
	logic [CNT_W-1:0]  lp_eff, lp_new;
	logic              wr_ok, proc;
	logic [ADDR_W-1:0] fidx;

	assign lp_eff = done_q ? '0 : lp_q;
	assign wr_ok  = lp_eff < total;
	assign lp_new = lp_eff + CNT_W'(wr_ok);
	assign proc   = lp_new >= total;
	assign fidx   = ({1'b0, fp_q} >= total) ? '0 : fp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q   <= '0;
			fp_q   <= '0;
			done_q <= 1'b0;
		end else begin
			if (cmd.op == OP_LOAD) begin
				lp_q   <= lp_new;
				done_q <= proc;
				if (done_q)
					fp_q <= '0;
			end else if (cmd.op == OP_FETCH_OUT) begin
				fp_q <= (fidx == last_idx) ? '0 : fidx + 1'b1;
			end
		end
	end

	// sweep index and its column and row
	logic [ADDR_W-1:0] i_q;
	logic [COL_W-1:0]  cx_q;
	logic [ROW_W-1:0]  cy_q;
	logic              last_i;
	logic              sweep_adv;

	assign last_i    = i_q == last_idx;
	assign sweep_adv = cmd.op == OP_KEY_WR || cmd.op == OP_CTR_NEXT ||
		cmd.op == OP_MG_WR;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD || (sweep_adv && last_i)) begin
			i_q  <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else if (sweep_adv) begin
			i_q <= i_q + 1'b1;
			if ({1'b0, cx_q} == DIM_W'(w_eff - 1'b1)) begin
				cx_q <= '0;
				cy_q <= cy_q + 1'b1;
			end else begin
				cx_q <= cx_q + 1'b1;
			end
		end
	end

	// quotient table over window divisors
	logic [INC_W-1:0] qt_q [QT_DEPTH];
	logic [DIV_W-1:0] d_q;
	logic [INC_W-1:0] quo;
	logic             div_done;

	cka_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV_START),
		.dividend (halo_inc_q),
		.divisor  (d_q),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD)
			d_q <= DIV_W'(1);
		else if (cmd.op == OP_DIV_STORE) begin
			qt_q[d_q] <= quo;
			d_q       <= d_q + 1'b1;
		end
	end

	// window around the current center
	logic [COL_W-1:0] x0_q, xl_q, x_q;
	logic [ROW_W-1:0] yl_q, y_q;
	logic [COL_W+1:0] x_hi;
	logic [ROW_W+1:0] y_hi;
	logic [COL_W-1:0] dx;
	logic [ROW_W-1:0] dy;
	logic [DIV_W-1:0] dv_q;
	logic [ADDR_W-1:0] paddr_q;
	logic              win_last;

	assign x_hi = (COL_W+2)'(cx_q) + (COL_W+2)'(s_eff);
	assign y_hi = (ROW_W+2)'(cy_q) + (ROW_W+2)'(s_eff);
	assign dx   = (x_q >= cx_q) ? x_q - cx_q : cx_q - x_q;
	assign dy   = (y_q >= cy_q) ? y_q - cy_q : cy_q - y_q;
	assign win_last = x_q == xl_q && y_q == yl_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_WIN_SET: begin
				x0_q <= (cx_q > COL_W'(s_eff)) ? cx_q - COL_W'(s_eff) : '0;
				x_q  <= (cx_q > COL_W'(s_eff)) ? cx_q - COL_W'(s_eff) : '0;
				y_q  <= (cy_q > ROW_W'(s_eff)) ? cy_q - ROW_W'(s_eff) : '0;
				xl_q <= (x_hi < (COL_W+2)'(w_eff - 1'b1)) ?
					COL_W'(x_hi) : COL_W'(w_eff - 1'b1);
				yl_q <= (y_hi < (ROW_W+2)'(h_eff - 1'b1)) ?
					ROW_W'(y_hi) : ROW_W'(h_eff - 1'b1);
			end
			OP_PT_ADDR: begin
				paddr_q <= ADDR_W'(y_q) * ADDR_W'(w_eff) + ADDR_W'(x_q);
				dv_q    <= DIV_W'((DIV_W+1)'(1) + {(DIV_W+1)'(s_eff), 1'b0} -
					(DIV_W+1)'(dx) - (DIV_W+1)'(dy));
			end
			OP_PT_WR: begin
				if (x_q == xl_q) begin
					x_q <= x0_q;
					y_q <= y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// pixel and accumulator memories
	logic [31:0]       store_mem [2**ADDR_W];
	logic [7:0]        acc_mem   [2**ADDR_W];
	logic [31:0]       rd_q;
	logic [7:0]        acc_rd_q;
	logic [ADDR_W-1:0] raddr, araddr;
	logic              keyed;
	logic [8:0]        mg_sum;
	logic [INC_W:0]    pt_sum;
	logic [7:0]        mg_alpha;

	assign raddr  = cmd.rd_ctr ? i_q : fidx;
	assign araddr = cmd.acc_pt ? paddr_q : i_q;
	assign keyed  = rd_q[23:0] == {key_b_q, key_g_q, key_r_q};
	assign mg_sum = 9'(rd_q[31:24]) + 9'(acc_rd_q);
	assign pt_sum = (INC_W+1)'(acc_rd_q) + (INC_W+1)'(qt_q[dv_q]);
	assign mg_alpha = (rd_q[31:24] == 8'hff) ? 8'hff :
		(mg_sum[8] ? 8'hff : mg_sum[7:0]);

	always_ff @(posedge clk) begin
		rd_q     <= store_mem[raddr];
		acc_rd_q <= acc_mem[araddr];
		case (cmd.op)
			OP_LOAD: begin
				if (wr_ok)
					store_mem[ADDR_W'(lp_eff)] <= {in_alpha, in_blue, in_green, in_red};
			end
			OP_KEY_WR: begin
				store_mem[i_q] <= keyed ? {8'h00, rd_q[23:0]} : rd_q;
				acc_mem[i_q]   <= '0;
			end
			OP_PT_WR: begin
				acc_mem[paddr_q] <= (pt_sum > (INC_W+1)'(255)) ? 8'hff : pt_sum[7:0];
			end
			OP_MG_WR: begin
				store_mem[i_q] <= {mg_alpha, rd_q[23:0]};
			end
			default: ;
		endcase
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_FETCH_OUT)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FETCH_OUT) begin
			out_red   <= rd_q[7:0];
			out_green <= rd_q[15:8];
			out_blue  <= rd_q[23:16];
			out_alpha <= rd_q[31:24];
			is_last   <= fidx == last_idx;
		end
	end

	assign out_valid = out_valid_q;

	// status to the controller
	always_comb begin
		stat.load_proc = proc;
		stat.fetch_ok  = done_q;
		stat.last_i    = last_i;
		stat.keyed     = keyed;
		stat.win_last  = win_last;
		stat.div_done  = div_done;
		stat.d_last    = d_q == DIV_W'({s_eff, 1'b1});
		stat.s_zero    = s_eff == '0;
		stat.out_free  = !out_valid_q || !out_stall;
	end

endmodule

>>> design/cka_ctrl.sv
// ----------------------------------------------------------------------------
// cka_ctrl
// Controller: takes beats, sequences the key, quotient, halo and merge
// passes and the fetch path of the datapath.
// ----------------------------------------------------------------------------
module cka_ctrl import cka_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      action,
	input  cka_stat_t stat,
	output logic      in_stall,
	output cka_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_KEY_RD = 4'd1;
	localparam logic [3:0] ST_KEY_WR = 4'd2;
	localparam logic [3:0] ST_DIV_GO = 4'd3;
	localparam logic [3:0] ST_DIV_WT = 4'd4;
	localparam logic [3:0] ST_C_RD   = 4'd5;
	localparam logic [3:0] ST_C_CHK  = 4'd6;
	localparam logic [3:0] ST_C_NX   = 4'd7;
	localparam logic [3:0] ST_P_ADDR = 4'd8;
	localparam logic [3:0] ST_P_RD   = 4'd9;
	localparam logic [3:0] ST_P_WR   = 4'd10;
	localparam logic [3:0] ST_M_RD   = 4'd11;
	localparam logic [3:0] ST_M_WR   = 4'd12;
	localparam logic [3:0] ST_F_OUT  = 4'd13;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign in_stall = state_q != ST_IDLE;

	// next state and datapath command
	always_comb begin
		state_d    = state_q;
		cmd.op     = OP_NONE;
		cmd.rd_ctr = 1'b0;
		cmd.acc_pt = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!action) begin
						cmd.op = OP_LOAD;
						if (stat.load_proc)
							state_d = ST_KEY_RD;
					end else if (stat.fetch_ok) begin
						state_d = ST_F_OUT;
					end
				end
			end
			ST_KEY_RD: begin
				cmd.rd_ctr = 1'b1;
				state_d    = ST_KEY_WR;
			end
			ST_KEY_WR: begin
				cmd.op = OP_KEY_WR;
				if (!stat.last_i)
					state_d = ST_KEY_RD;
				else if (stat.s_zero)
					state_d = ST_IDLE;
				else
					state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.op  = OP_DIV_START;
				state_d = ST_DIV_WT;
			end
			ST_DIV_WT: begin
				if (stat.div_done) begin
					cmd.op  = OP_DIV_STORE;
					state_d = stat.d_last ? ST_C_RD : ST_DIV_GO;
				end
			end
			ST_C_RD: begin
				cmd.rd_ctr = 1'b1;
				state_d    = ST_C_CHK;
			end
			ST_C_CHK: begin
				if (stat.keyed) begin
					state_d = ST_C_NX;
				end else begin
					cmd.op  = OP_WIN_SET;
					state_d = ST_P_ADDR;
				end
			end
			ST_C_NX: begin
				cmd.op  = OP_CTR_NEXT;
				state_d = stat.last_i ? ST_M_RD : ST_C_RD;
			end
			ST_P_ADDR: begin
				cmd.op  = OP_PT_ADDR;
				state_d = ST_P_RD;
			end
			ST_P_RD: begin
				cmd.acc_pt = 1'b1;
				state_d    = ST_P_WR;
			end
			ST_P_WR: begin
				cmd.op  = OP_PT_WR;
				state_d = stat.win_last ? ST_C_NX : ST_P_ADDR;
			end
			ST_M_RD: begin
				cmd.rd_ctr = 1'b1;
				state_d    = ST_M_WR;
			end
			ST_M_WR: begin
				cmd.op  = OP_MG_WR;
				state_d = stat.last_i ? ST_IDLE : ST_M_RD;
			end
			ST_F_OUT: begin
				if (stat.out_free) begin
					cmd.op  = OP_FETCH_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> design/color_key_alpha_halo.sv
// ----------------------------------------------------------------------------
// color_key_alpha_halo
// Chroma key transparency with an alpha halo over one stored frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry an action and an RGBA pixel. A load beat (action 0)
//   writes the next pixel in row-major order. The beat that completes the
//   frame starts processing; in_stall stays high while the frame is
//   processed: a keying pass over every pixel, and with a nonzero halo
//   width a quotient table over the window divisors (2s+1 of them), a halo
//   pass that adds to the accumulator at each window point of each non-key
//   pixel by a single-port read-modify-write, then a merge pass.
//   A served fetch beat (action 1) holds the input while the fetch output
//   state waits for a free output register, then puts the next processed
//   pixel in the output register; a fetch before processing yields nothing.
//   One item is in flight at a time.
//   If the receiver stalls, the result holds in the output register and a
//   pending fetch waits for it to drain.
//   Configuration writes go through cfg_write/cfg_index/cfg_data and are
//   to be made while the block is idle; the block does not enforce it.
//   Reset clears positions, the processed flag, the output valid and the
//   registers to their defaults; pixel memory contents stay undefined.
// ----------------------------------------------------------------------------
module color_key_alpha_halo import cka_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             action,
	input  logic [7:0]       in_red,
	input  logic [7:0]       in_green,
	input  logic [7:0]       in_blue,
	input  logic [7:0]       in_alpha,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic [7:0]       out_alpha,
	output logic             is_last
);

	cka_cmd_t  cmd;
	cka_stat_t stat;

	// sequencer
	cka_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// storage and arithmetic
	cka_data u_data (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.in_alpha  (in_alpha),
		.cmd       (cmd),
		.out_stall (out_stall),
		.stat      (stat),
		.out_valid (out_valid),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.out_alpha (out_alpha),
		.is_last   (is_last)
	);

endmodule

>>> tb/sv/tb_color_key_alpha_halo.sv
// ----------------------------------------------------------------------------
// tb_color_key_alpha_halo
// Loads small frames into the color key alpha halo block under many key,
// halo and frame size settings, fetches them back and compares every
// fetched pixel with an in-bench model of keying and halo accumulation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_color_key_alpha_halo;
	import cka_pkg::*;

	typedef enum bit {ACT_LOAD = 1'b0, ACT_FETCH = 1'b1} act_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} pix_t;

	typedef struct packed {
		pix_t p;
		logic last;
	} fetched_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_write;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic             action;
	logic [7:0]       in_red, in_green, in_blue, in_alpha;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       out_red, out_green, out_blue, out_alpha;
	logic             is_last;

	color_key_alpha_halo uut (.*);

	// shadow of the block state
	pix_t        frame_mem [0:MAX_WIDTH*MAX_HEIGHT-1];
	int          halo_acc [0:MAX_WIDTH*MAX_HEIGHT-1];
	logic [7:0]  key_r, key_g, key_b;
	logic [3:0]  halo_s;
	logic [15:0] halo_inc;
	logic [8:0]  frame_w, frame_h;
	int          load_pos, fetch_pos;
	bit          frame_ready;
	int          settle_cycles;

	fetched_t    pending_pixels [$];
	int          fails, n_results, n_beats, n_frames;
	int          send_pct, stall_pct;
	int          hold_req;
	int          hold_cnt;

	// clock and timeout
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("color_key_alpha_halo: mismatch");
		$finish;
	end

	function automatic int clamp_dim(logic [8:0] v);
		if (v < 1) return 1;
		if (v > 256) return 256;
		return v;
	endfunction

	function automatic bit keyed(pix_t p);
		return p.r == key_r && p.g == key_g && p.b == key_b;
	endfunction

	// keying, then halo accumulation around every non-key pixel and the merge into alpha
	function automatic void process_frame(int w, int h);
		int n, s, cx, cy, x, y, dx, dy, d, win, alpha;
		n = w * h;
		s = halo_s;
		for (int i = 0; i < n; i++)
			if (keyed(frame_mem[i])) frame_mem[i].a = 8'd0;
		win = (2*s + 1) * (2*s + 1);
		if (win > n) win = n;
		settle_cycles = 7*n + 18*(2*s + 1) + 3*n*win + 100;
		if (s == 0) return;
		for (int i = 0; i < n; i++) halo_acc[i] = 0;
		for (int i = 0; i < n; i++) begin
			if (keyed(frame_mem[i])) continue;
			cx = i % w;
			cy = i / w;
			for (y = (cy > s ? cy - s : 0); y < cy + s + 1 && y < h; y++) begin
				dy = y > cy ? y - cy : cy - y;
				for (x = (cx > s ? cx - s : 0); x < cx + s + 1 && x < w; x++) begin
					dx = x > cx ? x - cx : cx - x;
					d = 1 + 2*s - dx - dy;
					halo_acc[y*w + x] += halo_inc / d;
					if (halo_acc[y*w + x] > 255) halo_acc[y*w + x] = 255;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			alpha = frame_mem[i].a;
			if (alpha != 255) begin
				alpha += halo_acc[i];
				frame_mem[i].a = alpha > 255 ? 8'd255 : alpha[7:0];
			end
		end
	endfunction

	// effect of one accepted beat
	function automatic void predict_beat(act_t act, pix_t p);
		int total;
		fetched_t e;
		total = clamp_dim(frame_w) * clamp_dim(frame_h);
		if (act == ACT_LOAD) begin
			if (frame_ready) begin
				frame_ready = 0;
				load_pos = 0;
				fetch_pos = 0;
			end
			if (load_pos < total) begin
				frame_mem[load_pos] = p;
				load_pos++;
			end
			if (load_pos >= total) begin
				process_frame(clamp_dim(frame_w), clamp_dim(frame_h));
				frame_ready = 1;
				n_frames++;
			end
			return;
		end
		if (!frame_ready) return;
		if (fetch_pos >= total) fetch_pos = 0;
		e.p = frame_mem[fetch_pos];
		e.last = fetch_pos == total - 1;
		pending_pixels = {pending_pixels, e};
		fetch_pos++;
		if (fetch_pos >= total) fetch_pos = 0;
	endfunction

	// receiver stall, with an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_cnt <= 0;
		end else begin
			if (hold_req > 0) begin
				hold_cnt <= hold_req;
				hold_req = 0;
				out_stall <= 1'b1;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= $urandom_range(99) < stall_pct;
			end
		end
	end

	// result check
	always @(posedge clk) begin
		fetched_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_pixels.size() == 0) begin
				$error("unexpected result beat");
				fails++;
			end else begin
				e = pending_pixels.pop_front();
				if (out_red !== e.p.r) begin
					$error("out_red exp %0d got %0d", e.p.r, out_red); fails++;
				end
				if (out_green !== e.p.g) begin
					$error("out_green exp %0d got %0d", e.p.g, out_green); fails++;
				end
				if (out_blue !== e.p.b) begin
					$error("out_blue exp %0d got %0d", e.p.b, out_blue); fails++;
				end
				if (out_alpha !== e.p.a) begin
					$error("out_alpha exp %0d got %0d", e.p.a, out_alpha); fails++;
				end
				if (is_last !== e.last) begin
					$error("is_last exp %0d got %0d", e.last, is_last); fails++;
				end
			end
		end
	end

	// one input beat; records it at the edge that accepted it, then may drop in_valid for a random gap
	task automatic send_beat(act_t act, pix_t p);
		in_valid <= 1'b1;
		action   <= act;
		in_red   <= p.r;
		in_green <= p.g;
		in_blue  <= p.b;
		in_alpha <= p.a;
		do @(posedge clk); while (in_stall);
		predict_beat(act, p);
		n_beats++;
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// wait for all results plus any processing still under way
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (settle_cycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, int val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
		case (idx)
			REG_KEY_RED:    key_r = 8'(val);
			REG_KEY_GREEN:  key_g = 8'(val);
			REG_KEY_BLUE:   key_b = 8'(val);
			REG_HALO_WIDTH: halo_s = 4'(val);
			REG_HALO_INC:   halo_inc = 16'(val);
			REG_FRAME_W:    frame_w = 9'(val);
			REG_FRAME_H:    frame_h = 9'(val);
			default: ;
		endcase
	endtask

	task automatic set_regs(int kr, int kg, int kb, int s, int inc, int w, int h);
		drain_block();
		write_reg(REG_KEY_RED, kr);
		write_reg(REG_KEY_GREEN, kg);
		write_reg(REG_KEY_BLUE, kb);
		write_reg(REG_HALO_WIDTH, s);
		write_reg(REG_HALO_INC, inc);
		write_reg(REG_FRAME_W, w);
		write_reg(REG_FRAME_H, h);
		cfg_write <= 1'b0;
	endtask

	function automatic pix_t rand_pixel();
		pix_t p;
		p = $urandom;
		case ($urandom_range(3))
			0: begin p.r = key_r; p.g = key_g; p.b = key_b; end
			1: begin
				p.r = key_r; p.g = key_g; p.b = key_b;
				p.r[$urandom_range(7)] ^= 1'b1;
			end
			default: ;
		endcase
		case ($urandom_range(3))
			0: p.a = 8'd0;
			1: p.a = 8'd255;
			default: ;
		endcase
		return p;
	endfunction

	// load a whole frame with some early fetches mixed in when noise is set, then read it back
	task automatic run_frame(int n, int extra, bit noise);
		for (int i = 0; i < n; i++) begin
			send_beat(ACT_LOAD, rand_pixel());
			if (noise && i < n - 1 && $urandom_range(9) == 0)
				send_beat(ACT_FETCH, $urandom);
		end
		for (int i = 0; i < n + extra; i++) send_beat(ACT_FETCH, $urandom);
	endtask

	// fetch before anything is processed, tiny frame, keying, wrap
	task automatic test_basic_frame();
		send_beat(ACT_FETCH, 32'hFFFF_FFFF);
		set_regs(0, 0, 0, 0, 0, 2, 2);
		send_beat(ACT_LOAD, 32'h5500_0000);
		send_beat(ACT_FETCH, 32'h0);
		send_beat(ACT_LOAD, 32'hFFFF_FFFF);
		send_beat(ACT_LOAD, 32'h8001_0000);
		send_beat(ACT_LOAD, 32'h0000_0000);
		repeat (5) send_beat(ACT_FETCH, 32'h0);
	endtask

	// out-of-range frame sizes and the widest halo
	task automatic test_clamping();
		set_regs(255, 255, 255, 1, 65535, 0, 0);
		run_frame(1, 1, 0);
		set_regs(255, 0, 128, 15, 65535, 300, 1);
		run_frame(256, 0, 0);
		set_regs(1, 2, 3, 15, 0, 1, 511);
		run_frame(256, 0, 0);
	endtask

	// frame shrunk during loading, then shrunk again after processing
	task automatic test_shrink();
		set_regs(9, 9, 9, 2, 300, 4, 4);
		repeat (6) send_beat(ACT_LOAD, rand_pixel());
		set_regs(9, 9, 9, 2, 300, 2, 2);
		send_beat(ACT_LOAD, rand_pixel());
		repeat (2) send_beat(ACT_FETCH, 32'h0);
		set_regs(9, 9, 9, 2, 300, 1, 1);
		repeat (2) send_beat(ACT_FETCH, 32'h0);
	endtask

	// random frames under all idle mixes, with one long hold-off
	task automatic test_random_frames();
		int w, h, inc;
		int phase;
		phase = 0;
		while (n_beats < 1040) begin
			case (phase % 4)
				0: begin send_pct = 0;  stall_pct = 0;  end
				1: begin send_pct = 56; stall_pct = 0;  end
				2: begin send_pct = 0;  stall_pct = 56; end
				default: begin send_pct = 11; stall_pct = 11; end
			endcase
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 8);
			case ($urandom_range(3))
				0: inc = 0;
				1: inc = 65535;
				2: inc = $urandom_range(1, 400);
				default: inc = $urandom_range(65535);
			endcase
			set_regs($urandom_range(255), $urandom_range(255), $urandom_range(255),
				$urandom_range(15), inc, w, h);
			if (phase == 5) begin
				for (int i = 0; i < w*h; i++) send_beat(ACT_LOAD, rand_pixel());
				@(negedge clk) hold_req = 300;
				@(posedge clk);
				for (int i = 0; i < w*h + 3; i++) send_beat(ACT_FETCH, $urandom);
			end else begin
				run_frame(w*h, $urandom_range(2), 1);
			end
			phase++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; action = 1'b0;
		in_red = '0; in_green = '0; in_blue = '0; in_alpha = '0;
		key_r = 0; key_g = 0; key_b = 0; halo_s = 0; halo_inc = 0;
		frame_w = 256; frame_h = 256;
		load_pos = 0; fetch_pos = 0; frame_ready = 0; settle_cycles = 0;
		fails = 0; n_results = 0; n_beats = 0; n_frames = 0;
		send_pct = 0; stall_pct = 0; hold_req = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_frame();
		test_clamping();
		test_shrink();
		test_random_frames();

		in_valid <= 1'b0;
		for (int i = 0; i < 200000 && pending_pixels.size() != 0; i++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			$error("%0d fetched pixels never arrived", pending_pixels.size());
			fails++;
		end
		$display("covered %0d beats over %0d processed frames, %0d pixels checked",
			n_beats, n_frames, n_results);
		if (fails == 0)
			$display("color_key_alpha_halo: match");
		else
			$display("color_key_alpha_halo: mismatch");
		$finish;
	end

endmodule

>>> sim.f
design/cka_pkg.sv
design/cka_div.sv
design/cka_data.sv
design/cka_ctrl.sv
design/color_key_alpha_halo.sv
tb/sv/tb_color_key_alpha_halo.sv
